// ===== src/ctwc_pkg.sv =====
// shared types and codes for the circle versus wall tile collision block
package ctwc_pkg;

  // operation codes carried on the input tuser
  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  // configuration register indexes
  localparam logic REG_WALL_LOW  = 1'b0;
  localparam logic REG_WALL_HIGH = 1'b1;

  localparam logic [3:0] WALL_LOW_RST  = 4'd3;
  localparam logic [3:0] WALL_HIGH_RST = 4'd11;

  // one stored tile
  typedef struct packed {
    logic [11:0]        height;
    logic [11:0]        width;
    logic signed [15:0] top;
    logic signed [15:0] left;
    logic [3:0]         kind;
  } tile_entry_t;

  localparam int TILE_W = $bits(tile_entry_t);

  // circle under test, squared radius formed once per query
  typedef struct packed {
    logic signed [15:0] cx;
    logic signed [15:0] cy;
    logic [23:0]        rsq;
  } query_t;

  // tag traveling beside the memory read data
  typedef struct packed {
    logic vld;
    logic last;
    logic live;
  } scan_tag_t;

  // per-tile outcome from the test pipeline
  typedef struct packed {
    logic vld;
    logic last;
    logic hit;
  } test_res_t;

endpackage

// ===== src/circle_tile_wall_collision.sv =====
// top level: tile store, scan sequencer, config registers and result register
//
//  channel | ports                        | payload
//  --------+------------------------------+-----------------------------------------
//  input   | in_tvalid/in_tready          | tuser: operation; tdata: tile and circle
//  result  | out_tvalid/out_tready        | tdata[0]: hit, one per query
//  config  | cfg_valid/cfg_ready          | cfg_index, cfg_data (4 bits)
//
// a tile write gives no result. reset clears the valid flags; no clearing pass is needed.
// a query reads one tile entry per cycle from the ram, so a scan covers min(TILE_COUNT,256)
// entries; the hit is ready after the last entry passes the read and test pipeline.
// reset sets the config registers to their reset values. the input stalls until a query's
// hit is placed in the output register; a finished hit waits there while the next item is
// taken, and a later hit waits in place until that transfer.
module circle_tile_wall_collision
  import ctwc_pkg::*;
#(
  parameter int TILE_COUNT = 256
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  // [7:0] tile_index, [11:8] tile_kind, [27:12] box_left, [43:28] box_top,
  // [55:44] box_width, [67:56] box_height, [83:68] center_x, [99:84] center_y,
  // [111:100] radius
  input  logic [111:0] in_tdata,
  // [0] operation
  input  logic         in_tuser,
  output logic         out_tvalid,
  input  logic         out_tready,
  // [0] hit, [7:1] zero
  output logic [7:0]   out_tdata,
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic         cfg_index,
  input  logic [3:0]   cfg_data
);

  // tile_index is 8 bits wide, so no entry past 255 can ever be written
  localparam int DEPTH = (TILE_COUNT < 256) ? TILE_COUNT : 256;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_SCAN  = 4'b0010,
    ST_FLUSH = 4'b0100,
    ST_WAIT  = 4'b1000
  } state_t;

  state_t      state_r, state_nxt;
  logic [3:0]  wall_low_r, wall_high_r;
  logic [DEPTH-1:0] valid_r, valid_nxt;
  logic [AW-1:0] scan_addr_r, scan_addr_nxt;
  query_t      query_r;
  logic        hit_acc_r, hit_acc_nxt;
  logic        out_tvalid_r, out_tvalid_nxt;
  logic        out_hit_r, out_hit_nxt;
  scan_tag_t   tag_r, tag_nxt;
  test_res_t   res;
  tile_entry_t wr_entry, rd_entry;
  logic [TILE_W-1:0] rd_bits;

  logic [7:0]  in_index;
  logic        in_xfer, wr_en, query_start, scan_last, out_free;

  assign in_index    = in_tdata[7:0];
  assign in_xfer     = in_tvalid && in_tready;
  assign wr_en       = in_xfer && (in_tuser == OP_WRITE) && (32'(in_index) < TILE_COUNT);
  assign query_start = in_xfer && (in_tuser == OP_QUERY);
  assign scan_last   = (scan_addr_r == AW'(DEPTH - 1));
  assign out_free    = !out_tvalid_r || out_tready;

  assign in_tready = (state_r == ST_IDLE);
  assign cfg_ready = 1'b1;

  always_comb begin
    wr_entry.kind   = in_tdata[11:8];
    wr_entry.left   = in_tdata[27:12];
    wr_entry.top    = in_tdata[43:28];
    wr_entry.width  = in_tdata[55:44];
    wr_entry.height = in_tdata[67:56];
  end

  ctwc_ram #(
    .WIDTH (TILE_W),
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_tile_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (in_index[AW-1:0]),
    .wr_data (wr_entry),
    .rd_en   (state_r == ST_SCAN),
    .rd_addr (scan_addr_r),
    .rd_data (rd_bits)
  );

  assign rd_entry = tile_entry_t'(rd_bits);

  ctwc_tile_test u_test (
    .clk       (clk),
    .rst_n     (rst_n),
    .query     (query_r),
    .wall_low  (wall_low_r),
    .wall_high (wall_high_r),
    .tile      (rd_entry),
    .tag       (tag_r),
    .res       (res)
  );

  always_comb begin
    valid_nxt = valid_r;
    if (wr_en) begin
      valid_nxt[in_index[AW-1:0]] = 1'b1;
    end
  end

  always_comb begin
    tag_nxt.vld  = (state_r == ST_SCAN);
    tag_nxt.last = scan_last;
    tag_nxt.live = valid_r[scan_addr_r];
  end

  always_comb begin
    state_nxt      = state_r;
    scan_addr_nxt  = scan_addr_r;
    hit_acc_nxt    = hit_acc_r;
    out_tvalid_nxt = out_tvalid_r && !out_tready;
    out_hit_nxt    = out_hit_r;

    if (res.vld) begin
      hit_acc_nxt = hit_acc_r | res.hit;
    end

    case (state_r)
      ST_IDLE: begin
        if (query_start) begin
          state_nxt     = ST_SCAN;
          scan_addr_nxt = '0;
          hit_acc_nxt   = 1'b0;
        end
      end
      ST_SCAN: begin
        scan_addr_nxt = scan_addr_r + 1'b1;
        if (scan_last) begin
          state_nxt = ST_FLUSH;
        end
      end
      ST_FLUSH: begin
        // last tile result closes the query
        if (res.vld && res.last) begin
          if (out_free) begin
            out_tvalid_nxt = 1'b1;
            out_hit_nxt    = hit_acc_nxt;
            state_nxt      = ST_IDLE;
          end else begin
            state_nxt = ST_WAIT;
          end
        end
      end
      ST_WAIT: begin
        if (out_free) begin
          out_tvalid_nxt = 1'b1;
          out_hit_nxt    = hit_acc_r;
          state_nxt      = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (query_start) begin
      query_r.cx  <= in_tdata[83:68];
      query_r.cy  <= in_tdata[99:84];
      query_r.rsq <= in_tdata[111:100] * in_tdata[111:100];
    end
    out_hit_r <= out_hit_nxt;
    hit_acc_r <= hit_acc_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      scan_addr_r  <= '0;
      valid_r      <= '0;
      tag_r        <= '0;
      out_tvalid_r <= 1'b0;
      wall_low_r   <= WALL_LOW_RST;
      wall_high_r  <= WALL_HIGH_RST;
    end else begin
      state_r      <= state_nxt;
      scan_addr_r  <= scan_addr_nxt;
      valid_r      <= valid_nxt;
      tag_r        <= tag_nxt;
      out_tvalid_r <= out_tvalid_nxt;
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_WALL_LOW:  wall_low_r  <= cfg_data;
          REG_WALL_HIGH: wall_high_r <= cfg_data;
          default: ;
        endcase
      end
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = {7'b0, out_hit_r};

endmodule

// ===== src/ctwc_ram.sv =====
// generic single-write, single-read ram with registered read data
module ctwc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// ===== src/ctwc_tile_test.sv =====
// three-stage circle versus box test: clamp gap, square, sum and compare
module ctwc_tile_test
  import ctwc_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  query_t      query,
  input  logic [3:0]  wall_low,
  input  logic [3:0]  wall_high,
  input  tile_entry_t tile,
  input  scan_tag_t   tag,
  output test_res_t   res
);

  // distance from c to the interval [lo, lo+len], never negative
  function automatic logic [15:0] axis_gap(input logic signed [15:0] c,
                                           input logic signed [15:0] lo,
                                           input logic [11:0] len);
    logic signed [16:0] c17;
    logic signed [16:0] lo17;
    logic signed [16:0] hi17;
    logic signed [16:0] d;
    c17  = 17'(c);
    lo17 = 17'(lo);
    hi17 = lo17 + $signed({5'b0, len});
    if (c17 < lo17) begin
      d = lo17 - c17;
    end else if (c17 > hi17) begin
      d = c17 - hi17;
    end else begin
      d = '0;
    end
    return d[15:0];
  endfunction

  logic        is_wall;
  logic [15:0] gx_nxt, gy_nxt;
  logic [15:0] gx_r, gy_r;
  logic        a_vld_r, a_last_r, a_wall_r;
  logic [31:0] sqx_r, sqy_r;
  logic        b_vld_r, b_last_r, b_wall_r;
  logic [32:0] dist_sq;
  test_res_t   res_r, res_nxt;

  assign is_wall = tag.live && (tile.kind >= wall_low) && (tile.kind <= wall_high);
  assign gx_nxt  = axis_gap(query.cx, tile.left, tile.width);
  assign gy_nxt  = axis_gap(query.cy, tile.top, tile.height);

  assign dist_sq = {1'b0, sqx_r} + {1'b0, sqy_r};

  always_comb begin
    res_nxt.vld  = b_vld_r;
    res_nxt.last = b_last_r;
    res_nxt.hit  = b_vld_r && b_wall_r && (dist_sq < {9'b0, query.rsq});
  end

  always_ff @(posedge clk) begin
    gx_r  <= gx_nxt;
    gy_r  <= gy_nxt;
    sqx_r <= gx_r * gx_r;
    sqy_r <= gy_r * gy_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_vld_r  <= 1'b0;
      a_last_r <= 1'b0;
      a_wall_r <= 1'b0;
      b_vld_r  <= 1'b0;
      b_last_r <= 1'b0;
      b_wall_r <= 1'b0;
      res_r    <= '0;
    end else begin
      a_vld_r  <= tag.vld;
      a_last_r <= tag.vld && tag.last;
      a_wall_r <= is_wall;
      b_vld_r  <= a_vld_r;
      b_last_r <= a_last_r;
      b_wall_r <= a_wall_r;
      res_r    <= res_nxt;
    end
  end

  assign res = res_r;

endmodule

// ===== sim/circle_tile_wall_collision_tb.sv =====
// self-checking testbench for the circle versus wall tile collision block
module circle_tile_wall_collision_tb
  import ctwc_pkg::*;
();

  localparam int TILE_SLOTS    = 256;
  localparam int SETTLE_CYCLES = 300;      // one full scan plus pipeline, with margin
  localparam int HOLD_CYCLES   = 3000;
  localparam int LIMIT_CYCLES  = 3000000;
  localparam int PHASE_ITEMS   = 225;

  // input item as carried on in_tdata, highest field first
  typedef struct packed {
    logic [11:0]        radius;
    logic signed [15:0] cy;
    logic signed [15:0] cx;
    logic [11:0]        height;
    logic [11:0]        width;
    logic signed [15:0] top;
    logic signed [15:0] left;
    logic [3:0]         kind;
    logic [7:0]         index;
  } in_fields_t;

  typedef enum {RX_ALWAYS, RX_HALF, RX_SPARSE, RX_MOSTLY} rx_mode_t;

  logic         clk;
  logic         rst_n;
  logic         in_tvalid;
  logic         in_tready;
  logic [111:0] in_tdata;
  logic         in_tuser;
  logic         out_tvalid;
  logic         out_tready;
  logic [7:0]   out_tdata;
  logic         cfg_valid;
  logic         cfg_ready;
  logic         cfg_index;
  logic [3:0]   cfg_data;

  // predictor state
  bit          tile_valid [TILE_SLOTS];
  tile_entry_t tile_store [TILE_SLOTS];
  logic [3:0]  wall_lo;
  logic [3:0]  wall_hi;
  bit          hit_expect_q [$];

  int       mismatch_count;
  int       cycle_count;
  int       burst_left;
  // a hold starts each time hold_request toggles
  bit       hold_request;
  bit       hold_taken;
  int       hold_left;
  rx_mode_t ready_mode;
  int       mode_left;

  circle_tile_wall_collision u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  function automatic longint clamp_to_span(longint c, longint lo, longint len);
    if (c < lo) return lo;
    if (c > lo + len) return lo + len;
    return c;
  endfunction

  // any valid tile inside the wall range closer than the radius
  function automatic bit circle_hits_wall(in_fields_t q);
    longint cx;
    longint cy;
    longint rr;
    longint dx;
    longint dy;
    bit     found;
    cx = longint'(q.cx);
    cy = longint'(q.cy);
    rr = longint'(q.radius);
    found = 1'b0;
    for (int i = 0; i < TILE_SLOTS; i++) begin
      if (!found && tile_valid[i] && tile_store[i].kind >= wall_lo &&
          tile_store[i].kind <= wall_hi) begin
        dx = clamp_to_span(cx, longint'(tile_store[i].left),
                           longint'(tile_store[i].width)) - cx;
        dy = clamp_to_span(cy, longint'(tile_store[i].top),
                           longint'(tile_store[i].height)) - cy;
        if (dx * dx + dy * dy < rr * rr) found = 1'b1;
      end
    end
    return found;
  endfunction

  function automatic in_fields_t random_fields();
    logic [127:0] raw;
    raw = {$urandom(), $urandom(), $urandom(), $urandom()};
    return raw[111:0];
  endfunction

  function automatic logic [15:0] sat16(int v);
    if (v > 32767) return 16'h7fff;
    if (v < -32768) return 16'h8000;
    return v[15:0];
  endfunction

  // unused query fields stay random
  function automatic in_fields_t make_write(logic [7:0] idx, logic [3:0] kind,
                                            logic [15:0] left, logic [15:0] top,
                                            logic [11:0] width, logic [11:0] height);
    in_fields_t f;
    f = random_fields();
    f.index  = idx;
    f.kind   = kind;
    f.left   = left;
    f.top    = top;
    f.width  = width;
    f.height = height;
    return f;
  endfunction

  function automatic in_fields_t make_query(logic [15:0] cx, logic [15:0] cy,
                                            logic [11:0] radius);
    in_fields_t f;
    f = random_fields();
    f.cx     = cx;
    f.cy     = cy;
    f.radius = radius;
    return f;
  endfunction

  // circle placed around a stored tile so that it lands near the box edges
  function automatic in_fields_t aimed_query();
    in_fields_t f;
    int         idx;
    int         r;
    int         x0;
    int         y0;
    idx = $urandom_range(0, TILE_SLOTS - 1);
    for (int k = 0; k < 16 && !tile_valid[idx]; k++) idx = $urandom_range(0, TILE_SLOTS - 1);
    r = ($urandom_range(0, 3) != 0) ? $urandom_range(1, 400) : $urandom_range(0, 4095);
    x0 = int'($signed(tile_store[idx].left)) - r - 2 +
         int'($urandom_range(0, int'(tile_store[idx].width) + 2 * r + 4));
    y0 = int'($signed(tile_store[idx].top)) - r - 2 +
         int'($urandom_range(0, int'(tile_store[idx].height) + 2 * r + 4));
    f = random_fields();
    f.cx     = sat16(x0);
    f.cy     = sat16(y0);
    f.radius = r[11:0];
    return f;
  endfunction

  // one input transfer, bursts separated by random gaps
  task automatic send_item(logic op, in_fields_t f);
    int gap;
    @(negedge clk);
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
      if (gap > 0) begin
        in_tvalid = 1'b0;
        repeat (gap) @(negedge clk);
      end
      burst_left = $urandom_range(1, 16);
    end
    burst_left--;
    in_tvalid = 1'b1;
    in_tuser  = op;
    in_tdata  = f;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    if (op == OP_WRITE) begin
      tile_valid[f.index] = 1'b1;
      tile_store[f.index] = '{height: f.height, width: f.width, top: f.top,
                              left: f.left, kind: f.kind};
    end else begin
      hit_expect_q.push_back(circle_hits_wall(f));
    end
  endtask

  task automatic wait_idle();
    @(negedge clk);
    in_tvalid  = 1'b0;
    burst_left = 0;
    while (hit_expect_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(logic idx, logic [3:0] value);
    @(negedge clk);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data  = value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    if (idx == REG_WALL_LOW) wall_lo = value;
    else wall_hi = value;
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  task automatic set_wall_range(logic [3:0] lo, logic [3:0] hi);
    wait_idle();
    write_reg(REG_WALL_LOW, lo);
    write_reg(REG_WALL_HIGH, hi);
  endtask

  task automatic test_empty_store();
    send_item(OP_QUERY, make_query(16'd0, 16'd0, 12'd4095));
    send_item(OP_QUERY, make_query(16'h8000, 16'h8000, 12'd4095));
  endtask

  task automatic test_tile_geometry();
    // point box in the far corner, kind at the bottom of the wall range
    send_item(OP_WRITE, make_write(8'd0, 4'd3, 16'h8000, 16'h8000, 12'd0, 12'd0));
    send_item(OP_QUERY, make_query(16'h8000, 16'h8005, 12'd5));
    send_item(OP_QUERY, make_query(16'h8000, 16'h8005, 12'd6));
    // largest box past the positive edge, kind at the top of the range
    send_item(OP_WRITE, make_write(8'd255, 4'd11, 16'h7fff, 16'h7fff, 12'd4095, 12'd4095));
    send_item(OP_QUERY, make_query(16'h7fff, 16'h7fff, 12'd0));
    send_item(OP_QUERY, make_query(16'h7fff, 16'h7fff, 12'd1));
    // kinds just outside the wall range
    send_item(OP_WRITE, make_write(8'd17, 4'd2, 16'd0, 16'd0, 12'd100, 12'd100));
    send_item(OP_WRITE, make_write(8'd18, 4'd12, 16'd0, 16'd0, 12'd100, 12'd100));
    send_item(OP_QUERY, make_query(16'd50, 16'd50, 12'd10));
    // edge and corner distances exactly at the radius, then one past
    send_item(OP_WRITE, make_write(8'd19, 4'd7, 16'd1000, 16'd1000, 12'd200, 12'd50));
    send_item(OP_QUERY, make_query(16'd990, 16'd1020, 12'd10));
    send_item(OP_QUERY, make_query(16'd990, 16'd1020, 12'd11));
    send_item(OP_QUERY, make_query(16'd1203, 16'd1054, 12'd5));
    send_item(OP_QUERY, make_query(16'd1203, 16'd1054, 12'd6));
    send_item(OP_QUERY, make_query(16'd1100, 16'd1020, 12'd1));
    // overwrite moves the tile out of the wall range
    send_item(OP_WRITE, make_write(8'd19, 4'd15, 16'd1000, 16'd1000, 12'd200, 12'd50));
    send_item(OP_QUERY, make_query(16'd1100, 16'd1020, 12'd1));
  endtask

  task automatic test_wall_range();
    set_wall_range(4'd0, 4'd15);
    send_item(OP_QUERY, make_query(16'd1100, 16'd1020, 12'd1));
    set_wall_range(4'd15, 4'd15);
    send_item(OP_QUERY, make_query(16'd1100, 16'd1020, 12'd1));
    send_item(OP_QUERY, make_query(16'd50, 16'd50, 12'd10));
    set_wall_range(4'd0, 4'd0);
    send_item(OP_QUERY, make_query(16'd50, 16'd50, 12'd10));
    // low above high leaves no wall at all
    set_wall_range(4'd12, 4'd4);
    send_item(OP_QUERY, make_query(16'd1100, 16'd1020, 12'd4095));
    set_wall_range(4'd12, 4'd12);
    send_item(OP_QUERY, make_query(16'd50, 16'd50, 12'd10));
  endtask

  task automatic test_random_traffic();
    logic [3:0] lo_list [6];
    logic [3:0] hi_list [6];
    in_fields_t f;
    int         pick;
    lo_list = '{4'd3, 4'd0, 4'd15, 4'd4, 4'd0, 4'd15};
    hi_list = '{4'd11, 4'd15, 4'd0, 4'd9, 4'd0, 4'd15};
    for (int p = 0; p < 7; p++) begin
      if (p < 6) set_wall_range(lo_list[p], hi_list[p]);
      else set_wall_range(4'($urandom_range(0, 15)), 4'($urandom_range(0, 15)));
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        pick = $urandom_range(0, 99);
        if (pick < 50) begin
          f = random_fields();
          if ($urandom_range(0, 3) != 0) begin
            f.left = 16'(int'($urandom_range(0, 8191)) - 4096);
            f.top  = 16'(int'($urandom_range(0, 8191)) - 4096);
          end
          if ($urandom_range(0, 4) != 0) begin
            f.width  = 12'($urandom_range(0, 255));
            f.height = 12'($urandom_range(0, 255));
          end
          send_item(OP_WRITE, f);
        end else if (pick < 80) begin
          send_item(OP_QUERY, aimed_query());
        end else begin
          f = random_fields();
          if ($urandom_range(0, 1) != 0) begin
            f.cx = 16'(int'($urandom_range(0, 8191)) - 4096);
            f.cy = 16'(int'($urandom_range(0, 8191)) - 4096);
          end
          if ($urandom_range(0, 1) != 0) f.radius = 12'($urandom_range(0, 400));
          send_item(OP_QUERY, f);
        end
      end
    end
  endtask

  // receiver holds off while queries keep coming, the block must back up
  task automatic test_output_stall();
    wait_idle();
    hold_request = ~hold_request;
    for (int n = 0; n < 14; n++) send_item(OP_QUERY, aimed_query());
  endtask

  // receiver: long hold on request, otherwise a changing ready pattern
  always @(negedge clk) begin
    if (hold_request != hold_taken) begin
      hold_taken = hold_request;
      hold_left  = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_tready = 1'b0;
    end else begin
      if (mode_left == 0) begin
        ready_mode = rx_mode_t'($urandom_range(0, 3));
        mode_left  = $urandom_range(8, 200);
      end
      mode_left--;
      case (ready_mode)
        RX_ALWAYS: out_tready = 1'b1;
        RX_HALF:   out_tready = 1'($urandom_range(0, 1));
        RX_SPARSE: out_tready = ($urandom_range(0, 3) == 0);
        default:   out_tready = ($urandom_range(0, 7) != 0);
      endcase
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      if (hit_expect_q.size() == 0) begin
        $display("%0t: result with nothing expected, got %0d", $time, out_tdata);
        mismatch_count++;
      end else if (out_tdata != {7'd0, hit_expect_q[0]}) begin
        $display("%0t: hit mismatch, expected %0d, got %0d", $time,
                 {7'd0, hit_expect_q[0]}, out_tdata);
        mismatch_count++;
        void'(hit_expect_q.pop_front());
      end else begin
        void'(hit_expect_q.pop_front());
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > LIMIT_CYCLES) begin
      $display("circle_tile_wall_collision_tb failed");
      $finish;
    end
  end

  initial begin
    rst_n      = 1'b0;
    in_tvalid  = 1'b0;
    in_tdata   = '0;
    in_tuser   = OP_WRITE;
    cfg_valid  = 1'b0;
    cfg_index  = REG_WALL_LOW;
    cfg_data   = '0;
    wall_lo    = WALL_LOW_RST;
    wall_hi    = WALL_HIGH_RST;
    burst_left = 0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    test_empty_store();
    test_tile_geometry();
    test_wall_range();
    test_random_traffic();
    test_output_stall();

    wait_idle();
    if (mismatch_count == 0) begin
      $display("circle_tile_wall_collision_tb passed");
    end else begin
      $display("circle_tile_wall_collision_tb failed");
    end
    $finish;
  end

endmodule

// ===== circle_tile_wall_collision.f =====
src/ctwc_pkg.sv
src/ctwc_ram.sv
src/ctwc_tile_test.sv
src/circle_tile_wall_collision.sv
sim/circle_tile_wall_collision_tb.sv
